// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the board-monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define IBMR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IBMR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ibmr_pkg.sv -----
// Package of constants, types and lookup functions for the board-monitor register file.
package ibmr_pkg;

    // Averaging configuration.
    localparam int CHANNEL_COUNT   = 16;
    localparam int AVG_DEPTH_SHIFT = 2;
    localparam int SAMPLE_BITS     = 12;
    localparam int REG_COUNT       = 68;

    // Field widths fixed by the bus-side item format.
    localparam int CHAN_W     = 4;
    localparam int CHAN_SLOTS = 1 << CHAN_W;
    localparam int ADC_W      = 12;
    localparam int PTR_W      = 7;
    localparam int CFG_IDX_W  = 2;

    // Ring and running total geometry.
    localparam int POS_W     = (AVG_DEPTH_SHIFT > 0) ? AVG_DEPTH_SHIFT : 1;
    localparam int RAM_AW    = CHAN_W + POS_W;
    localparam int RAM_DEPTH = 1 << RAM_AW;
    localparam int TOTAL_W   = SAMPLE_BITS + AVG_DEPTH_SHIFT;
    localparam logic [POS_W-1:0] RING_MASK = POS_W'((1 << AVG_DEPTH_SHIFT) - 1);

    // Item command codes.
    localparam logic [2:0] CMD_MATCH_WRITE = 3'd0;
    localparam logic [2:0] CMD_MATCH_READ  = 3'd1;
    localparam logic [2:0] CMD_WRITE_BYTE  = 3'd2;
    localparam logic [2:0] CMD_READ_BYTE   = 3'd3;
    localparam logic [2:0] CMD_STOP        = 3'd4;
    localparam logic [2:0] CMD_BUS_RESET   = 3'd5;
    localparam logic [2:0] CMD_ADC_SAMPLE  = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRMWARE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCB        = 2'd2;

    // Register map addresses.
    localparam logic [PTR_W-1:0] REG_BOARD_KIND    = 7'h00;
    localparam logic [PTR_W-1:0] REG_FIRMWARE      = 7'h01;
    localparam logic [PTR_W-1:0] REG_PCB           = 7'h02;
    localparam logic [PTR_W-1:0] REG_COMMAND       = 7'h03;
    localparam logic [PTR_W-1:0] REG_SOC_TEMP      = 7'h04;
    localparam logic [PTR_W-1:0] REG_BOARD_TEMP    = 7'h05;
    localparam logic [PTR_W-1:0] REG_INT_STATUS_LO = 7'h06;
    localparam logic [PTR_W-1:0] REG_INT_STATUS_HI = 7'h07;
    localparam logic [PTR_W-1:0] REG_INT_MASK_LO   = 7'h08;
    localparam logic [PTR_W-1:0] REG_INT_MASK_HI   = 7'h09;
    localparam logic [PTR_W-1:0] REG_AVG_FIRST     = 7'h29;
    localparam logic [PTR_W-1:0] REG_AVG_LAST      = 7'h43;
    localparam logic [PTR_W-1:0] PTR_LAST          = PTR_W'(REG_COUNT - 1);

    localparam logic [7:0] UNMAPPED_BYTE = 8'hff;

    // Multiples of the register count, used to wrap a written pointer byte.
    localparam logic [9:0] REG_COUNT_X1 = 10'(REG_COUNT);
    localparam logic [9:0] REG_COUNT_X2 = 10'(2 * REG_COUNT);
    localparam logic [9:0] REG_COUNT_X3 = 10'(3 * REG_COUNT);

    // Average map: one entry per address from the first to the last average register.
    localparam int AVG_MAP_LEN = 27;
    localparam logic [4:0] MAP_NONE = 5'h00;
    localparam logic [4:0] MAP_HIT  = 5'h10;
    localparam logic [4:0] AVG_MAP [AVG_MAP_LEN] = '{
        MAP_HIT | 5'd8,  MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE,
        MAP_HIT | 5'd0,  MAP_HIT | 5'd1,  MAP_HIT | 5'd2,  MAP_HIT | 5'd9,
        MAP_HIT | 5'd11, MAP_HIT | 5'd12, MAP_HIT | 5'd7,  MAP_HIT | 5'd6,
        MAP_HIT | 5'd14, MAP_HIT | 5'd5,
        MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE,
        MAP_HIT | 5'd10, MAP_HIT | 5'd13, MAP_HIT | 5'd15, MAP_HIT | 5'd4
    };

    // Request to fetch the oldest ring sample of a channel, issued when a sample item is accepted.
    typedef struct packed {
        logic              fire;
        logic [CHAN_W-1:0] channel;
    } ibmr_fetch_t;

    // Ring and running total update, issued when a sample item leaves the work stage.
    typedef struct packed {
        logic                   fire;
        logic [SAMPLE_BITS-1:0] value;
    } ibmr_update_t;

    // Result of an average map lookup.
    typedef struct packed {
        logic              hit;
        logic [CHAN_W-1:0] channel;
    } ibmr_slot_t;

    // Wrap a written byte into the register range with at most one subtraction of a register-count multiple.
    function automatic logic [PTR_W-1:0] ibmr_wrap_ptr(input logic [7:0] value);
        logic [9:0] x;
        x = {2'b00, value};
        if (x >= REG_COUNT_X3) begin
            x = x - REG_COUNT_X3;
        end else if (x >= REG_COUNT_X2) begin
            x = x - REG_COUNT_X2;
        end else if (x >= REG_COUNT_X1) begin
            x = x - REG_COUNT_X1;
        end
        return x[PTR_W-1:0];
    endfunction

    // Look up which channel average an address shows, if any.
    function automatic ibmr_slot_t ibmr_avg_slot(input logic [PTR_W-1:0] addr);
        ibmr_slot_t      slot;
        logic [4:0]      entry;
        logic [PTR_W-1:0] offset;
        slot   = '0;
        entry  = MAP_NONE;
        offset = addr - REG_AVG_FIRST;
        if (addr >= REG_AVG_FIRST && addr <= REG_AVG_LAST) begin
            entry = AVG_MAP[offset[4:0]];
        end
        slot.hit     = entry[4];
        slot.channel = entry[CHAN_W-1:0];
        return slot;
    endfunction

endpackage

// ----- rtl/ibmr_ram.sv -----
// Generic single-port-write, registered-read RAM.
module ibmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ibmr_avg.sv -----
// Per-channel moving averages: sample ring memory, ring positions and running totals.
module ibmr_avg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ibmr_pkg::ibmr_fetch_t        fetch,
    input  ibmr_pkg::ibmr_update_t       update,
    input  logic [ibmr_pkg::CHAN_W-1:0]  rd_channel,
    output logic [7:0]                   rd_avg_low
);
    import ibmr_pkg::*;

    logic [POS_W-1:0]       pos_reg [CHAN_SLOTS];
    logic [TOTAL_W-1:0]     total_reg [CHAN_SLOTS];
    logic [RAM_DEPTH-1:0]   written_reg;
    logic [RAM_AW-1:0]      addr_reg;
    logic                   fwd_reg;
    logic                   seen_reg;
    logic [SAMPLE_BITS-1:0] fwd_data_reg;

    logic [POS_W-1:0]       fetch_pos;
    logic [RAM_AW-1:0]      fetch_addr;
    logic                   fetch_fwd;
    logic [CHAN_W-1:0]      upd_channel;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [TOTAL_W-1:0]     avg_full;

    // Address of the oldest sample of the fetched channel.
    assign fetch_pos   = pos_reg[fetch.channel];
    assign fetch_addr  = {fetch.channel, fetch_pos};
    assign fetch_fwd   = update.fire && (addr_reg == fetch_addr);
    assign upd_channel = addr_reg[RAM_AW-1 -: CHAN_W];

    // Ring positions advance when the fetch is issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAN_SLOTS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else if (fetch.fire)
        begin
            pos_reg[fetch.channel] <= POS_W'(fetch_pos + 1'b1) & RING_MASK;
        end
    end

    // Fetch bookkeeping: a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg  <= 1'b0;
            seen_reg <= 1'b0;
        end
        else if (fetch.fire)
        begin
            fwd_reg  <= fetch_fwd;
            seen_reg <= written_reg[fetch_addr] || fetch_fwd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch.fire)
        begin
            addr_reg     <= fetch_addr;
            fwd_data_reg <= update.value;
        end
    end

    // An entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (update.fire)
        begin
            written_reg[addr_reg] <= 1'b1;
        end
    end

    assign old_sample = fwd_reg  ? fwd_data_reg :
                        seen_reg ? ram_rdata    : '0;

    // Running totals: drop the oldest sample, add the new one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAN_SLOTS; i++)
            begin
                total_reg[i] <= '0;
            end
        end
        else if (update.fire)
        begin
            total_reg[upd_channel] <= total_reg[upd_channel] - TOTAL_W'(old_sample)
                                      + TOTAL_W'(update.value);
        end
    end

    ibmr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (update.fire),
        .waddr (addr_reg),
        .wdata (update.value),
        .re    (fetch.fire),
        .raddr (fetch_addr),
        .rdata (ram_rdata)
    );

    // Average of the requested channel, low byte only.
    assign avg_full   = total_reg[rd_channel] >> AVG_DEPTH_SHIFT;
    assign rd_avg_low = avg_full[7:0];

endmodule

// ----- rtl/i2c_board_monitor_regs_core.sv -----
// Top level of the board-monitor register file with per-channel moving averages.
//
// Usage: one input channel (in_valid/in_stall) carries bus events and converter
// samples; every accepted transfer gives exactly one result transfer on the output
// channel (out_valid/out_stall) with read_data, read_valid and active_command.
// Configuration (board type, firmware and PCB version) must be written through
// cfg_we/cfg_index/cfg_data while the block is idle; the block does not enforce this.
// Each accepted item passes through the work stage and then the output register,
// from which its result is presented. Throughput is one item per cycle while the
// receiver does not stall: the work stage and the output register each hold one
// item, and the sample ring memory is read when an item is accepted and written
// when it leaves the work stage.
// When the receiver stalls, the output register holds its result and the work
// stage keeps the next item; in_stall rises only when both are occupied and the
// receiver stalls.
// Reset clears the pointer state, commands, configuration, ring positions and
// running totals; ring entries read as zero until written, so no clearing pass is
// needed and items are taken from the first cycle after reset.
`include "assert_macros.svh"

module i2c_board_monitor_regs_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ibmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     command,
    input  logic [7:0]                     data_byte,
    input  logic [ibmr_pkg::CHAN_W-1:0]    adc_channel,
    input  logic [ibmr_pkg::ADC_W-1:0]     adc_value,
    input  logic [7:0]                     soc_temp,
    input  logic [7:0]                     board_temp,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     read_data,
    output logic                           read_valid,
    output logic [7:0]                     active_command
);
    import ibmr_pkg::*;

    // Configuration registers.
    logic [7:0] board_type_reg;
    logic [7:0] firmware_reg;
    logic [7:0] pcb_reg;

    // Work stage.
    logic                   a_valid_reg;
    logic [2:0]             a_cmd_reg;
    logic [7:0]             a_data_reg;
    logic [CHAN_W-1:0]      a_chan_reg;
    logic [SAMPLE_BITS-1:0] a_value_reg;
    logic [7:0]             a_soc_reg;
    logic [7:0]             a_brd_reg;

    // Bus-side state.
    logic             ptr_pending_reg;
    logic             ptr_pending_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [7:0]       pend_cmd_reg;
    logic [7:0]       pend_cmd_next;
    logic [7:0]       latched_cmd_reg;
    logic [7:0]       latched_cmd_next;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] read_data_reg;
    logic       read_valid_reg;
    logic [7:0] active_command_reg;

    logic             accept;
    logic             a_move;
    logic [PTR_W-1:0] ptr_inc;
    logic [7:0]       rd_byte;
    logic [7:0]       avg_low;
    ibmr_slot_t       slot;
    ibmr_fetch_t      fetch;
    ibmr_update_t     update;

    // Handshake: the work stage empties whenever the output register can take its result.
    assign a_move   = a_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = a_valid_reg && !a_move;
    assign accept   = in_valid && !in_stall;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_type_reg <= '0;
            firmware_reg   <= '0;
            pcb_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOARD_TYPE: board_type_reg <= cfg_data;
                CFG_FIRMWARE:   firmware_reg   <= cfg_data;
                CFG_PCB:        pcb_reg        <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Work stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Work stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_cmd_reg   <= command;
            a_data_reg  <= data_byte;
            a_chan_reg  <= adc_channel;
            a_value_reg <= SAMPLE_BITS'(adc_value);
            a_soc_reg   <= soc_temp;
            a_brd_reg   <= board_temp;
        end
    end

    // Sample fetch at acceptance, ring update when the sample leaves the work stage.
    always_comb
    begin
        fetch.fire    = accept && (command == CMD_ADC_SAMPLE) && (adc_channel < CHANNEL_COUNT);
        fetch.channel = adc_channel;
        update.fire   = a_move && (a_cmd_reg == CMD_ADC_SAMPLE) && (a_chan_reg < CHANNEL_COUNT);
        update.value  = a_value_reg;
    end

    ibmr_avg u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .fetch      (fetch),
        .update     (update),
        .rd_channel (slot.channel),
        .rd_avg_low (avg_low)
    );

    // Register read at the current pointer.
    assign slot = ibmr_avg_slot(ptr_reg);

    always_comb
    begin
        case (ptr_reg)
            REG_BOARD_KIND:  rd_byte = board_type_reg;
            REG_FIRMWARE:    rd_byte = firmware_reg;
            REG_PCB:         rd_byte = pcb_reg;
            REG_SOC_TEMP:    rd_byte = a_soc_reg;
            REG_BOARD_TEMP:  rd_byte = a_brd_reg;
            REG_COMMAND, REG_INT_STATUS_LO, REG_INT_STATUS_HI,
            REG_INT_MASK_LO, REG_INT_MASK_HI:
                rd_byte = 8'h00;
            default:
            begin
                if (slot.hit && (slot.channel < CHANNEL_COUNT))
                begin
                    rd_byte = avg_low;
                end
                else
                begin
                    rd_byte = UNMAPPED_BYTE;
                end
            end
        endcase
    end

    // Pointer and command state after the item in the work stage.
    assign ptr_inc = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        ptr_pending_next = ptr_pending_reg;
        ptr_next         = ptr_reg;
        pend_cmd_next    = pend_cmd_reg;
        latched_cmd_next = latched_cmd_reg;
        case (a_cmd_reg)
            CMD_MATCH_WRITE:
                ptr_pending_next = 1'b1;
            CMD_WRITE_BYTE:
            begin
                if (ptr_pending_reg)
                begin
                    ptr_next         = ibmr_wrap_ptr(a_data_reg);
                    ptr_pending_next = 1'b0;
                end
                else
                begin
                    if (ptr_reg == REG_COMMAND)
                    begin
                        pend_cmd_next = a_data_reg;
                    end
                    ptr_next = ptr_inc;
                end
            end
            CMD_READ_BYTE:
                ptr_next = ptr_inc;
            CMD_STOP:
                latched_cmd_next = pend_cmd_reg;
            CMD_BUS_RESET:
            begin
                ptr_pending_next = 1'b0;
                ptr_next         = '0;
                pend_cmd_next    = '0;
                latched_cmd_next = '0;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_pending_reg <= 1'b0;
            ptr_reg         <= '0;
            pend_cmd_reg    <= '0;
            latched_cmd_reg <= '0;
        end
        else if (a_move)
        begin
            ptr_pending_reg <= ptr_pending_next;
            ptr_reg         <= ptr_next;
            pend_cmd_reg    <= pend_cmd_next;
            latched_cmd_reg <= latched_cmd_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            read_data_reg      <= (a_cmd_reg == CMD_READ_BYTE) ? rd_byte : 8'h00;
            read_valid_reg     <= (a_cmd_reg == CMD_READ_BYTE);
            active_command_reg <= latched_cmd_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = read_data_reg;
    assign read_valid     = read_valid_reg;
    assign active_command = active_command_reg;

    // Assertions.
    `IBMR_ASSERT(a_ptr_range, ptr_reg < REG_COUNT, "register pointer out of range")
    `IBMR_ASSERT(a_read_result, a_move && (a_cmd_reg == CMD_READ_BYTE) |=> out_valid_reg && read_valid_reg, "read transfer lost its read flag")
    `IBMR_ASSERT(a_other_result, a_move && (a_cmd_reg != CMD_READ_BYTE) |=> !read_valid_reg && (read_data_reg == 8'h00), "non-read transfer returned data")
    `IBMR_ASSERT(a_bus_reset, a_move && (a_cmd_reg == CMD_BUS_RESET) |=> active_command_reg == 8'h00, "bus reset left a command latched")
    `IBMR_ASSERT_ALWAYS(a_stall_empty, !a_valid_reg |-> !in_stall, "input stalled with an empty work stage")

endmodule

// ----- dv/ibmr_result_checker.sv -----
// Reply checker for the board-monitor register file: predicts every reply and compares it.
module ibmr_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ibmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [2:0]                     command,
    input  logic [7:0]                     data_byte,
    input  logic [ibmr_pkg::CHAN_W-1:0]    adc_channel,
    input  logic [ibmr_pkg::ADC_W-1:0]     adc_value,
    input  logic [7:0]                     soc_temp,
    input  logic [7:0]                     board_temp,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     read_data,
    input  logic                           read_valid,
    input  logic [7:0]                     active_command,
    output int                             mismatches,
    output int                             awaiting,
    output int                             reads_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ibmr_pkg::*;

    localparam int RING_SLOTS   = 1 << AVG_DEPTH_SHIFT;
    localparam int REPORT_LIMIT = 10;

    // One reply transfer as seen on the output channel.
    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic [7:0] active_command;
    } bus_reply_t;

    // Identification bytes as last written over the configuration port.
    logic [7:0] board_type_q;
    logic [7:0] firmware_q;
    logic [7:0] pcb_q;

    // Bus-side state: pointer handling and the command register.
    logic             pointer_armed;
    logic [PTR_W-1:0] reg_ptr;
    logic [7:0]       staged_cmd;
    logic [7:0]       live_cmd;

    // Moving-average state per converter channel.
    logic [SAMPLE_BITS-1:0] samples [CHAN_SLOTS][RING_SLOTS];
    logic [POS_W-1:0]       slot_next [CHAN_SLOTS];
    logic [TOTAL_W-1:0]     sample_sum [CHAN_SLOTS];
    logic [SAMPLE_BITS-1:0] mean_value [CHAN_SLOTS];

    bus_reply_t replies_due [$];
    bus_reply_t reply_want;
    bus_reply_t reply_got;
    int         fail_total;
    int         read_total;

    // Channel whose average low byte shows at an address, or -1 where none does.
    function automatic int mean_channel_at(input logic [PTR_W-1:0] addr);
        case (addr)
            7'h29:   return 8;
            7'h30:   return 0;
            7'h31:   return 1;
            7'h32:   return 2;
            7'h33:   return 9;
            7'h34:   return 11;
            7'h35:   return 12;
            7'h36:   return 7;
            7'h37:   return 6;
            7'h38:   return 14;
            7'h39:   return 5;
            7'h40:   return 10;
            7'h41:   return 13;
            7'h42:   return 15;
            7'h43:   return 4;
            default: return -1;
        endcase
    endfunction

    // Byte that a read returns at the given register address.
    function automatic logic [7:0] register_byte(input logic [PTR_W-1:0] addr,
                                                 input logic [7:0] soc,
                                                 input logic [7:0] brd);
        int ch;
        ch = mean_channel_at(addr);
        case (addr)
            REG_BOARD_KIND: return board_type_q;
            REG_FIRMWARE:   return firmware_q;
            REG_PCB:        return pcb_q;
            REG_SOC_TEMP:   return soc;
            REG_BOARD_TEMP: return brd;
            REG_COMMAND, REG_INT_STATUS_LO, REG_INT_STATUS_HI,
            REG_INT_MASK_LO, REG_INT_MASK_HI:
                return 8'h00;
            default:
                return (ch >= 0) ? mean_value[ch][7:0] : UNMAPPED_BYTE;
        endcase
    endfunction

    // Apply one accepted input transfer to the state and return the reply it causes.
    function automatic bus_reply_t apply_bus_event(input logic [2:0]             cmd,
                                                   input logic [7:0]             data,
                                                   input logic [CHAN_W-1:0]      ch,
                                                   input logic [SAMPLE_BITS-1:0] val,
                                                   input logic [7:0]             soc,
                                                   input logic [7:0]             brd);
        bus_reply_t       reply;
        logic [POS_W-1:0] pos;
        reply = '0;
        case (cmd)
            CMD_MATCH_WRITE: pointer_armed = 1'b1;
            CMD_WRITE_BYTE:
            begin
                if (pointer_armed)
                begin
                    reg_ptr       = PTR_W'(int'(data) % REG_COUNT);
                    pointer_armed = 1'b0;
                end
                else
                begin
                    if (reg_ptr == REG_COMMAND)
                    begin
                        staged_cmd = data;
                    end
                    reg_ptr = (reg_ptr == PTR_LAST) ? '0 : reg_ptr + 1'b1;
                end
            end
            CMD_READ_BYTE:
            begin
                reply.read_data  = register_byte(reg_ptr, soc, brd);
                reply.read_valid = 1'b1;
                reg_ptr = (reg_ptr == PTR_LAST) ? '0 : reg_ptr + 1'b1;
            end
            CMD_STOP: live_cmd = staged_cmd;
            CMD_BUS_RESET:
            begin
                pointer_armed = 1'b0;
                reg_ptr       = '0;
                staged_cmd    = 8'h00;
                live_cmd      = 8'h00;
            end
            CMD_ADC_SAMPLE:
            begin
                // The oldest sample in the ring drops out of the running total.
                pos              = slot_next[ch];
                sample_sum[ch]   = sample_sum[ch] - samples[ch][pos] + val;
                samples[ch][pos] = val;
                slot_next[ch]    = pos + 1'b1;
                mean_value[ch]   = SAMPLE_BITS'(sample_sum[ch] >> AVG_DEPTH_SHIFT);
            end
            default: ;
        endcase
        reply.active_command = live_cmd;
        return reply;
    endfunction

    // Compare each reply with the oldest prediction, then predict for the new transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_type_q  = 8'h00;
            firmware_q    = 8'h00;
            pcb_q         = 8'h00;
            pointer_armed = 1'b0;
            reg_ptr       = '0;
            staged_cmd    = 8'h00;
            live_cmd      = 8'h00;
            foreach (samples[c, s]) samples[c][s] = '0;
            foreach (slot_next[c])
            begin
                slot_next[c]  = '0;
                sample_sum[c] = '0;
                mean_value[c] = '0;
            end
            replies_due.delete();
            fail_total    = 0;
            read_total    = 0;
            mismatches    <= 0;
            awaiting      <= 0;
            reads_checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BOARD_TYPE: board_type_q = cfg_data;
                    CFG_FIRMWARE:   firmware_q   = cfg_data;
                    CFG_PCB:        pcb_q        = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                reply_got.read_data      = read_data;
                reply_got.read_valid     = read_valid;
                reply_got.active_command = active_command;
                if (replies_due.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                    begin
                        $display("%0t: reply with none awaited: data %02h valid %0d cmd %02h",
                                 $realtime, read_data, read_valid, active_command);
                    end
                end
                else
                begin
                    reply_want = replies_due.pop_front();
                    if (reply_want != reply_got)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                        begin
                            $display({"%0t: reply mismatch: expected data %02h valid %0d",
                                      " cmd %02h, got data %02h valid %0d cmd %02h"},
                                     $realtime, reply_want.read_data, reply_want.read_valid,
                                     reply_want.active_command, reply_got.read_data,
                                     reply_got.read_valid, reply_got.active_command);
                        end
                    end
                    else if (reply_got.read_valid)
                    begin
                        read_total++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                replies_due.push_back(apply_bus_event(command, data_byte, adc_channel,
                                                      adc_value, soc_temp, board_temp));
            end

            mismatches    <= fail_total;
            awaiting      <= replies_due.size();
            reads_checked <= read_total;
        end
    end

endmodule

// ----- dv/i2c_board_monitor_regs_core_tb.sv -----
// Testbench top for the board-monitor register file: clock, reset, stimulus and verdict.
module i2c_board_monitor_regs_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ibmr_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 600;
    localparam int PAUSE_EVERY     = 150;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [7:0]           cfg_data    = 8'h00;
    logic                 in_valid    = 1'b0;
    logic [2:0]           command     = CMD_MATCH_READ;
    logic [7:0]           data_byte   = 8'h00;
    logic [CHAN_W-1:0]    adc_channel = '0;
    logic [ADC_W-1:0]     adc_value   = '0;
    logic [7:0]           soc_temp    = 8'h00;
    logic [7:0]           board_temp  = 8'h00;
    logic                 out_stall   = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] active_command;

    int send_idle_pct  = 20;
    int recv_idle_pct  = 73;
    int transfers_sent = 0;
    int cycle_count    = 0;
    int mismatches;
    int awaiting;
    int reads_checked;

    i2c_board_monitor_regs_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .data_byte      (data_byte),
        .adc_channel    (adc_channel),
        .adc_value      (adc_value),
        .soc_temp       (soc_temp),
        .board_temp     (board_temp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .read_valid     (read_valid),
        .active_command (active_command)
    );

    ibmr_result_checker reply_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .data_byte      (data_byte),
        .adc_channel    (adc_channel),
        .adc_value      (adc_value),
        .soc_temp       (soc_temp),
        .board_temp     (board_temp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .read_valid     (read_valid),
        .active_command (active_command),
        .mismatches     (mismatches),
        .awaiting       (awaiting),
        .reads_checked  (reads_checked)
    );

    // Free-running clock with a 20 ns period.
    always #10 clk = ~clk;

    // The receiver stalls at random, independently of what it is offered.
    always @(posedge clk)
    begin
        out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d replies awaited.",
                     cycle_count, awaiting);
            $display("i2c_board_monitor_regs_core regression: fail");
            $finish;
        end
    end

    // Offer one input transfer, after idle cycles drawn one at a time, and hold it until taken.
    task automatic send_item(input logic [2:0]        cmd,
                             input logic [7:0]        data,
                             input logic [CHAN_W-1:0] ch,
                             input logic [ADC_W-1:0]  val,
                             input logic [7:0]        soc,
                             input logic [7:0]        brd);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        command     <= cmd;
        data_byte   <= data;
        adc_channel <= ch;
        adc_value   <= val;
        soc_temp    <= soc;
        board_temp  <= brd;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (cmd != CMD_MATCH_READ && cmd != CMD_UNUSED)
        begin
            transfers_sent++;
        end
    endtask

    // Bus event with random content in the fields that it does not use.
    task automatic send_bus(input logic [2:0] cmd, input logic [7:0] data);
        send_item(cmd, data, CHAN_W'($urandom), ADC_W'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    // Address match in the write direction followed by the pointer byte.
    task automatic set_pointer(input logic [7:0] ptr_byte);
        send_bus(CMD_MATCH_WRITE, 8'($urandom));
        send_bus(CMD_WRITE_BYTE, ptr_byte);
    endtask

    // Stop offering transfers until every awaited reply has come back.
    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three identification registers on consecutive edges.
    task automatic write_config(input logic [7:0] board, input logic [7:0] firmware,
                                input logic [7:0] pcb);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BOARD_TYPE;
        cfg_data  <= board;
        @(posedge clk);
        cfg_index <= CFG_FIRMWARE;
        cfg_data  <= firmware;
        @(posedge clk);
        cfg_index <= CFG_PCB;
        cfg_data  <= pcb;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Pointer byte weighted towards the command register and the mapped areas.
    function automatic logic [7:0] pick_pointer;
        int r;
        r = $urandom_range(99);
        if (r < 20)
        begin
            return 8'(REG_COMMAND);
        end
        else if (r < 45)
        begin
            return 8'($urandom_range(9));
        end
        else if (r < 75)
        begin
            return 8'($urandom_range(REG_AVG_LAST, REG_AVG_FIRST));
        end
        return 8'($urandom_range(255));
    endfunction

    // One random bus transaction, sample burst or stray event.
    task automatic random_transaction;
        int               sel;
        int               n;
        logic [ADC_W-1:0] val;
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            // Register write: pointer, a few data bytes, usually a stop.
            set_pointer(pick_pointer());
            n = $urandom_range(3);
            repeat (n) send_bus(CMD_WRITE_BYTE, 8'($urandom));
            if ($urandom_range(3) != 0)
            begin
                send_bus(CMD_STOP, 8'($urandom));
            end
        end
        else if (sel < 65)
        begin
            // Register read: pointer, sometimes a repeated start, then a run of reads.
            set_pointer(pick_pointer());
            if ($urandom_range(1) == 1)
            begin
                send_bus(CMD_MATCH_READ, 8'($urandom));
            end
            n = $urandom_range(6, 1);
            repeat (n) send_bus(CMD_READ_BYTE, 8'($urandom));
            send_bus(CMD_STOP, 8'($urandom));
        end
        else if (sel < 88)
        begin
            // Burst of converter samples, extremes included.
            n = $urandom_range(8, 1);
            repeat (n)
            begin
                case ($urandom_range(9))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = ADC_W'($urandom);
                endcase
                send_item(CMD_ADC_SAMPLE, 8'($urandom), CHAN_W'($urandom), val,
                          8'($urandom), 8'($urandom));
            end
        end
        else if (sel < 92)
        begin
            send_bus(CMD_BUS_RESET, 8'($urandom));
        end
        else
        begin
            send_item(3'($urandom_range(7)), 8'($urandom), CHAN_W'($urandom),
                      ADC_W'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // One phase of random traffic under a given flow-control mix and register setting.
    task automatic run_phase(input int send_pct, input int recv_pct,
                             input logic [7:0] board, input logic [7:0] firmware,
                             input logic [7:0] pcb);
        int goal;
        int next_pause;
        drain_results;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        write_config(board, firmware, pcb);
        goal       = transfers_sent + ITEMS_PER_PHASE;
        next_pause = transfers_sent + PAUSE_EVERY;
        while (transfers_sent < goal)
        begin
            random_transaction();
            if (transfers_sent >= next_pause)
            begin
                drain_results;
                next_pause += PAUSE_EVERY;
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_config(8'hff, 8'h00, 8'ha5);

        // Identification, temperature and zero registers from the reset pointer.
        send_item(CMD_READ_BYTE, 8'h00, 4'h0, 12'h000, 8'h00, 8'h00);
        send_item(CMD_READ_BYTE, 8'hff, 4'hf, 12'hfff, 8'hff, 8'hff);
        send_item(CMD_READ_BYTE, 8'h00, 4'h0, 12'h000, 8'h00, 8'h00);
        send_item(CMD_READ_BYTE, 8'h00, 4'h0, 12'h000, 8'h00, 8'h00);
        send_item(CMD_READ_BYTE, 8'h00, 4'h0, 12'h000, 8'hff, 8'h00);
        send_item(CMD_READ_BYTE, 8'h00, 4'h0, 12'h000, 8'h00, 8'hff);
        send_item(CMD_READ_BYTE, 8'h00, 4'h0, 12'h000, 8'h00, 8'h00);

        // Samples at the extremes of channel and value.
        send_item(CMD_ADC_SAMPLE, 8'h00, 4'h0, 12'hfff, 8'h00, 8'h00);
        send_item(CMD_ADC_SAMPLE, 8'h00, 4'hf, 12'hfff, 8'h00, 8'h00);
        send_item(CMD_ADC_SAMPLE, 8'h00, 4'h4, 12'h000, 8'h00, 8'h00);

        // A match read leaves the pointer set pending; a read meanwhile still advances.
        send_bus(CMD_MATCH_WRITE, 8'h00);
        send_bus(CMD_MATCH_READ, 8'h00);
        send_bus(CMD_READ_BYTE, 8'h00);
        send_bus(CMD_WRITE_BYTE, 8'h30);
        send_bus(CMD_READ_BYTE, 8'h00);

        // Largest pointer byte wraps into the average register area.
        set_pointer(8'hff);
        send_bus(CMD_READ_BYTE, 8'h00);

        // Command register write, a write past it, then a stop latches the command.
        set_pointer(8'(REG_COMMAND));
        send_bus(CMD_WRITE_BYTE, 8'hff);
        send_bus(CMD_WRITE_BYTE, 8'h00);
        send_bus(CMD_STOP, 8'h00);

        // Unused code is ignored; a bus reset clears the commands and pointer.
        send_bus(CMD_UNUSED, 8'h00);
        send_bus(CMD_BUS_RESET, 8'h00);

        // Last register of the map, then the pointer wraps to the first.
        set_pointer(8'(PTR_LAST));
        send_bus(CMD_READ_BYTE, 8'h00);
        send_bus(CMD_READ_BYTE, 8'h00);

        run_phase(20, 73, 8'h00, 8'hff, 8'($urandom));
        run_phase(73, 20, 8'($urandom), 8'($urandom), 8'h00);
        run_phase(0, 0, 8'($urandom), 8'h00, 8'hff);
        drain_results;

        $display("Sent %0d bus and sample transfers under three flow-control mixes and four",
                 transfers_sent);
        $display("identification settings; %0d read replies checked, %0d mismatching replies.",
                 reads_checked, mismatches);
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("i2c_board_monitor_regs_core regression: pass");
        end
        else
        begin
            $display("i2c_board_monitor_regs_core regression: fail");
        end
        $finish;
    end

endmodule
